@@ rtl/tgadec_pkg.sv @@
// Shared types and constants for the TGA run-length image decoder.
// Used by tgadec_core and tga_rle_image_decoder; no other dependencies.
package tgadec_pkg;

  // Result kind codes, carried on the result tuser
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SPAN   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  localparam int unsigned DataW  = 104;  // packed result tdata width
  localparam logic [7:0]  Alpha24 = 8'd255;

  // One decoded result from the core, valid in the cycle the byte is stepped
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] span_start;
    logic [7:0]  span_length;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] width;
    logic [15:0] height;
    logic        image_end;
  } result_t;

endpackage

@@ rtl/tgadec_core.sv @@
// Byte-wise TGA parser state and packet/pixel decode for one file stream.
// Depends on tgadec_pkg for the result struct and kind codes.
module tgadec_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,       // consume one byte this cycle
  input  logic [7:0]          byte_i,
  input  logic                start_i,      // byte is header byte 0 of a new file
  output tgadec_pkg::result_t result_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_HEADER_BAD,
    PH_SKIP_ID,
    PH_PACKET,
    PH_PIXEL,
    PH_IDLE
  } phase_e;

  // Header byte positions that matter
  localparam logic [4:0] HdrIdLen   = 5'd0;
  localparam logic [4:0] HdrCmap    = 5'd1;
  localparam logic [4:0] HdrType    = 5'd2;
  localparam logic [4:0] HdrWidthLo = 5'd12;
  localparam logic [4:0] HdrWidthHi = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrDepth   = 5'd16;
  localparam logic [4:0] HdrLast    = 5'd17;

  localparam logic [7:0] TypeRaw = 8'd2;
  localparam logic [7:0] TypeRle = 8'd10;
  localparam logic [7:0] Bpp24   = 8'd24;
  localparam logic [7:0] Bpp32   = 8'd32;

  phase_e      phase_q, phase_c, phase_d;
  logic [4:0]  hpos_q, hpos_c, hpos_d;
  logic [7:0]  id_left_q, id_left_c, id_left_d;
  logic [15:0] width_q, width_c, width_d;
  logic [15:0] height_q, height_c, height_d;
  logic        run_coded_q, run_coded_c, run_coded_d;
  logic        four_q, four_c, four_d;
  logic        cmap_q, cmap_c, cmap_d;
  logic [7:0]  pkt_left_q, pkt_left_c, pkt_left_d;
  logic        pkt_run_q, pkt_run_c, pkt_run_d;
  logic [1:0]  bip_q, bip_c, bip_d;
  logic [23:0] colour_q, colour_c, colour_d;
  logic [31:0] done_q, done_c, done_d;
  logic [31:0] remain_q, remain_c, remain_d;
  logic [31:0] total_q, total_d;

  logic [7:0]  len_raw, len;
  logic        last_byte, img_end;
  tgadec_pkg::result_t res;

  // Apply the restart before the byte is processed
  always_comb begin
    if (start_i) begin
      phase_c = PH_HEADER;   hpos_c = '0;      id_left_c = '0;
      width_c = '0;          height_c = '0;    run_coded_c = 1'b0;
      four_c = 1'b0;         cmap_c = 1'b0;    pkt_left_c = '0;
      pkt_run_c = 1'b0;      bip_c = '0;       colour_c = '0;
      done_c = '0;           remain_c = '0;
    end else begin
      phase_c = phase_q;     hpos_c = hpos_q;  id_left_c = id_left_q;
      width_c = width_q;     height_c = height_q; run_coded_c = run_coded_q;
      four_c = four_q;       cmap_c = cmap_q;  pkt_left_c = pkt_left_q;
      pkt_run_c = pkt_run_q; bip_c = bip_q;    colour_c = colour_q;
      done_c = done_q;       remain_c = remain_q;
    end
  end

  // Decode one byte
  always_comb begin
    phase_d = phase_c;     hpos_d = hpos_c;    id_left_d = id_left_c;
    width_d = width_c;     height_d = height_c; run_coded_d = run_coded_c;
    four_d = four_c;       cmap_d = cmap_c;    pkt_left_d = pkt_left_c;
    pkt_run_d = pkt_run_c; bip_d = bip_c;      colour_d = colour_c;
    done_d = done_c;       remain_d = remain_c;
    total_d = total_q;
    len_raw = 8'd1;
    len = 8'd1;
    last_byte = 1'b0;
    img_end = 1'b0;
    res = '0;
    res.kind = tgadec_pkg::KIND_HEADER;

    case (phase_c)
      PH_HEADER, PH_HEADER_BAD: begin
        hpos_d = hpos_c + 5'd1;
        case (hpos_c)
          HdrIdLen: id_left_d = byte_i;
          HdrCmap:  cmap_d = (byte_i != 8'd0);
          HdrType: begin
            run_coded_d = (byte_i == TypeRle);
            if (byte_i != TypeRaw && byte_i != TypeRle) phase_d = PH_HEADER_BAD;
          end
          HdrWidthLo:  width_d[7:0]   = byte_i;
          HdrWidthHi:  width_d[15:8]  = byte_i;
          HdrHeightLo: height_d[7:0]  = byte_i;
          HdrHeightHi: height_d[15:8] = byte_i;
          HdrDepth: begin
            four_d = (byte_i == Bpp32);
            if (byte_i != Bpp24 && byte_i != Bpp32) phase_d = PH_HEADER_BAD;
            // size is final here; register the pixel count for the last byte
            total_d = 32'(width_c) * 32'(height_c);
          end
          HdrLast: begin
            res.valid = 1'b1;
            if (phase_c == PH_HEADER_BAD || cmap_c) begin
              phase_d = PH_IDLE;
              res.kind = tgadec_pkg::KIND_ERROR;
            end else begin
              remain_d = total_q;
              done_d = '0;
              bip_d = '0;
              pkt_run_d = 1'b0;
              pkt_left_d = '0;
              img_end = (total_q == 32'd0);
              if (img_end)                phase_d = PH_IDLE;
              else if (id_left_c != 8'd0) phase_d = PH_SKIP_ID;
              else if (run_coded_c)       phase_d = PH_PACKET;
              else                        phase_d = PH_PIXEL;
              res.kind = tgadec_pkg::KIND_HEADER;
              res.image_end = img_end;
            end
          end
          default: ;
        endcase
      end

      PH_SKIP_ID: begin
        id_left_d = id_left_c - 8'd1;
        if (id_left_d == 8'd0) phase_d = run_coded_c ? PH_PACKET : PH_PIXEL;
      end

      PH_PACKET: begin
        pkt_run_d = byte_i[7];
        pkt_left_d = {1'b0, byte_i[6:0]} + 8'd1;
        bip_d = '0;
        phase_d = PH_PIXEL;
      end

      PH_PIXEL: begin
        // gather B, G, R; the fourth byte is alpha
        case (bip_c)
          2'd0: colour_d[7:0]   = byte_i;
          2'd1: colour_d[15:8]  = byte_i;
          2'd2: colour_d[23:16] = byte_i;
          default: ;
        endcase
        last_byte = four_c ? (bip_c == 2'd3) : (bip_c == 2'd2);
        if (!last_byte) begin
          bip_d = bip_c + 2'd1;
        end else begin
          bip_d = '0;
          len_raw = (run_coded_c && pkt_run_c) ? pkt_left_c : 8'd1;
          // clip the span at the image end
          img_end = ({24'd0, len_raw} >= remain_c);
          len = img_end ? remain_c[7:0] : len_raw;
          done_d = done_c + {24'd0, len};
          remain_d = remain_c - {24'd0, len};
          res.valid = 1'b1;
          res.kind = tgadec_pkg::KIND_SPAN;
          res.span_start = done_c;
          res.span_length = len;
          res.blue = colour_d[7:0];
          res.green = colour_d[15:8];
          res.red = colour_d[23:16];
          res.alpha = four_c ? byte_i : tgadec_pkg::Alpha24;
          res.image_end = img_end;
          if (img_end) begin
            phase_d = PH_IDLE;
          end else if (run_coded_c) begin
            if (pkt_run_c) begin
              phase_d = PH_PACKET;
            end else begin
              pkt_left_d = pkt_left_c - 8'd1;
              if (pkt_left_d == 8'd0) phase_d = PH_PACKET;
            end
          end
        end
      end

      default: ;  // idle: drop bytes until the next file start
    endcase

    res.width = width_c;
    res.height = height_c;
  end

  assign result_o = res;

  // Hold state; advance only on a stepped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hpos_q <= '0;
      id_left_q <= '0;
      width_q <= '0;
      height_q <= '0;
      run_coded_q <= 1'b0;
      four_q <= 1'b0;
      cmap_q <= 1'b0;
      pkt_left_q <= '0;
      pkt_run_q <= 1'b0;
      bip_q <= '0;
      colour_q <= '0;
      done_q <= '0;
      remain_q <= '0;
      total_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hpos_q <= hpos_d;
      id_left_q <= id_left_d;
      width_q <= width_d;
      height_q <= height_d;
      run_coded_q <= run_coded_d;
      four_q <= four_d;
      cmap_q <= cmap_d;
      pkt_left_q <= pkt_left_d;
      pkt_run_q <= pkt_run_d;
      bip_q <= bip_d;
      colour_q <= colour_d;
      done_q <= done_d;
      remain_q <= remain_d;
      total_q <= total_d;
    end
  end

endmodule

@@ rtl/tga_rle_image_decoder.sv @@
// TGA (type 2 / type 10) stream decoder: input byte register, tgadec_core, result register.
// A result beat is registered, and shown on the master side, once its last byte is stepped.
// Throughput: one byte per cycle, set by the single decode step per byte; a byte that would
// produce a result waits in the input register while the result register is held, and the
// input stalls until the receiver takes the held beat.
// Reset: asynchronous active low; parser returns to header byte 0, both stages empty.
// Depends on tgadec_pkg and tgadec_core.
module tga_rle_image_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tuser,  // [0] file_start
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] span_start, [39:32] span_length, [47:40] blue, [55:48] green,
  // [63:56] red, [71:64] alpha, [87:72] width_out, [103:88] height_out
  output logic [tgadec_pkg::DataW-1:0] m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,  // [1:0] kind
  output logic                         m_axis_tlast   // image_end
);

  logic                in_valid_q, in_valid_d;
  logic [7:0]          in_byte_q;
  logic                in_start_q;
  logic                advance;
  logic                out_valid_q, out_valid_d;
  tgadec_pkg::result_t res;
  tgadec_pkg::result_t out_q;

  tgadec_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .start_i  (in_start_q),
    .result_o (res)
  );

  // Step the held byte unless its result has nowhere to go
  assign advance = in_valid_q && (!res.valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !advance);
  assign out_valid_d = (advance && res.valid) || (out_valid_q && !m_axis_tready);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = out_q.kind;
  assign m_axis_tlast = out_q.image_end;
  assign m_axis_tdata = {out_q.height, out_q.width, out_q.alpha, out_q.red,
                         out_q.green, out_q.blue, out_q.span_length, out_q.span_start};

endmodule

@@ tb/tb_tga_rle_image_decoder.sv @@
// Self-checking testbench for tga_rle_image_decoder: feeds TGA byte streams, predicts each
// header, error and pixel span result in-line and checks the result stream beat by beat.
// Depends on tgadec_pkg and the decoder RTL only.
module tb_tga_rle_image_decoder;

  localparam int unsigned RandomItems   = 1830;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 8;

  // TGA header codes
  localparam logic [7:0] TypeRaw = 8'd2;
  localparam logic [7:0] TypeRle = 8'd10;
  localparam logic [7:0] Bpp24   = 8'd24;
  localparam logic [7:0] Bpp32   = 8'd32;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_HEADER_BAD,
    ST_SKIP_ID,
    ST_PACKET,
    ST_PIXEL,
    ST_IDLE
  } dec_state_e;

  typedef struct packed {
    tgadec_pkg::kind_e kind;
    logic [31:0] span_start;
    logic [7:0]  span_length;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] width;
    logic [15:0] height;
    logic        image_end;
  } tga_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
  } dir_row_t;

  // Empty 65535 x 0 image, sent without file_start right after reset
  localparam tga_result_t EmptyHeaderResult = '{tgadec_pkg::KIND_HEADER, 32'd0, 8'd0, 8'd0,
                                                8'd0, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1};
  localparam dir_row_t DirRows [20] = '{
    '{8'h00,   1'b0, 1'b0},  // no ID field, no file_start after reset
    '{8'h00,   1'b0, 1'b0},  // no colour map
    '{TypeRaw, 1'b0, 1'b0},
    '{8'hA5,   1'b0, 1'b0},  // colour map spec, ignored
    '{8'h5A,   1'b0, 1'b0},
    '{8'hFF,   1'b0, 1'b0},
    '{8'h00,   1'b0, 1'b0},
    '{8'hC3,   1'b0, 1'b0},
    '{8'hFF,   1'b0, 1'b0},  // x / y origin, ignored
    '{8'h7F,   1'b0, 1'b0},
    '{8'h80,   1'b0, 1'b0},
    '{8'h01,   1'b0, 1'b0},
    '{8'hFF,   1'b0, 1'b0},  // width 65535
    '{8'hFF,   1'b0, 1'b0},
    '{8'h00,   1'b0, 1'b0},  // height 0
    '{8'h00,   1'b0, 1'b0},
    '{Bpp32,   1'b0, 1'b0},
    '{8'hFF,   1'b0, 1'b1},  // attribute, ignored; empty image header
    '{8'hFF,   1'b0, 1'b0},  // trailing bytes, ignored
    '{8'h00,   1'b0, 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'd0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [tgadec_pkg::DataW-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  // Decoder state mirror
  dec_state_e  dec_state;
  logic [4:0]  hdr_pos;
  logic [7:0]  id_left;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        rle_file;
  logic        bpp32;
  logic        has_cmap;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  pix_byte;
  logic [23:0] colour_acc;
  logic [31:0] pix_done;
  logic [31:0] pix_total;

  tga_result_t expected_q [$];
  logic [7:0]  file_q [$];
  int unsigned bytes_sent = 0;
  int unsigned mismatch_count = 0;
  bit          gaps_on = 1'b1;
  bit          hold_off_req = 1'b0;

  tga_rle_image_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Return the parser to header byte 0
  task automatic reset_decoder();
    dec_state  = ST_HEADER;
    hdr_pos    = '0;
    id_left    = '0;
    img_w      = '0;
    img_h      = '0;
    rle_file   = 1'b0;
    bpp32      = 1'b0;
    has_cmap   = 1'b0;
    pkt_left   = '0;
    pkt_run    = 1'b0;
    pix_byte   = '0;
    colour_acc = '0;
    pix_done   = '0;
    pix_total  = '0;
  endtask

  // Advance the decoder mirror by one byte and work out the result it causes, if any
  task automatic decode_tga_byte(input logic [7:0] b, input logic st, output bit has,
                                 output tga_result_t res);
    logic [4:0]  pos;
    logic [1:0]  idx;
    int unsigned nbytes;
    logic [31:0] len;
    logic [31:0] remaining;
    has = 1'b0;
    res = '0;
    if (st) reset_decoder();
    case (dec_state)
      ST_HEADER, ST_HEADER_BAD: begin
        pos = hdr_pos;
        hdr_pos = hdr_pos + 5'd1;
        case (pos)
          5'd0: id_left = b;
          5'd1: has_cmap = (b != 8'd0);
          5'd2: begin
            rle_file = (b == TypeRle);
            if (b != TypeRaw && b != TypeRle) dec_state = ST_HEADER_BAD;
          end
          5'd12: img_w[7:0] = b;
          5'd13: img_w[15:8] = b;
          5'd14: img_h[7:0] = b;
          5'd15: img_h[15:8] = b;
          5'd16: begin
            bpp32 = (b == Bpp32);
            if (b != Bpp24 && b != Bpp32) dec_state = ST_HEADER_BAD;
          end
          default: ;
        endcase
        if (pos == 5'd17) begin
          has = 1'b1;
          res.width  = img_w;
          res.height = img_h;
          if (dec_state == ST_HEADER_BAD || has_cmap) begin
            dec_state = ST_IDLE;
            res.kind  = tgadec_pkg::KIND_ERROR;
          end else begin
            pix_total = 32'(img_w) * 32'(img_h);
            pix_done  = '0;
            pix_byte  = '0;
            pkt_run   = 1'b0;
            pkt_left  = '0;
            res.kind  = tgadec_pkg::KIND_HEADER;
            res.image_end = (pix_total == 0);
            if (pix_total == 0) dec_state = ST_IDLE;
            else if (id_left != 0) dec_state = ST_SKIP_ID;
            else dec_state = rle_file ? ST_PACKET : ST_PIXEL;
          end
        end
      end
      ST_SKIP_ID: begin
        id_left = id_left - 8'd1;
        if (id_left == 0) dec_state = rle_file ? ST_PACKET : ST_PIXEL;
      end
      ST_PACKET: begin
        pkt_run   = b[7];
        pkt_left  = {1'b0, b[6:0]} + 8'd1;
        pix_byte  = '0;
        dec_state = ST_PIXEL;
      end
      ST_PIXEL: begin
        idx = pix_byte;
        nbytes = bpp32 ? 4 : 3;
        if (idx < 3) colour_acc[8*idx +: 8] = b;
        if (idx + 1 < nbytes) begin
          pix_byte = idx + 2'd1;
        end else begin
          // Complete pixel: one span, clipped at the end of the image
          pix_byte = '0;
          len = (rle_file && pkt_run) ? 32'(pkt_left) : 32'd1;
          remaining = pix_total - pix_done;
          if (len > remaining) len = remaining;
          has = 1'b1;
          res.kind        = tgadec_pkg::KIND_SPAN;
          res.span_start  = pix_done;
          res.span_length = len[7:0];
          res.blue        = colour_acc[7:0];
          res.green       = colour_acc[15:8];
          res.red         = colour_acc[23:16];
          res.alpha       = bpp32 ? b : tgadec_pkg::Alpha24;
          res.width       = img_w;
          res.height      = img_h;
          pix_done = pix_done + len;
          res.image_end = (pix_done >= pix_total);
          if (res.image_end) begin
            dec_state = ST_IDLE;
          end else if (rle_file) begin
            if (pkt_run) begin
              dec_state = ST_PACKET;
            end else begin
              pkt_left = pkt_left - 8'd1;
              if (pkt_left == 0) dec_state = ST_PACKET;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one byte, wait for its beat, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
                           input tga_result_t typed_res);
    bit          has;
    tga_result_t res;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_tga_byte(b, st, has, res);
    if (typed) expected_q.push_back(typed_res);
    else if (has) expected_q.push_back(res);
    bytes_sent++;
  endtask

  task automatic push_pixel(input logic four);
    repeat (four ? 4 : 3) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Build one TGA file in file_q: mostly well-formed, some rejected, some cut short
  task automatic build_file(input bit want_good);
    int unsigned r;
    int unsigned id_len;
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned rem;
    int unsigned cnt;
    int unsigned npkt;
    int unsigned max_pkt;
    logic [7:0]  bad;
    bit          good;
    bit          rle;
    bit          run;
    logic [7:0]  bpp;
    file_q.delete();
    good = want_good || $urandom_range(0, 99) < 80;
    r = $urandom_range(0, 99);
    id_len = (r < 75) ? $urandom_range(0, 3) : (r < 98) ? $urandom_range(4, 20) : 255;
    rle = $urandom_range(0, 1);
    bpp = $urandom_range(0, 1) ? Bpp32 : Bpp24;
    r = $urandom_range(0, 99);
    if (want_good) begin
      w = 6;
      h = 4;
    end else if (r < 85) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
    end else if (r < 93) begin
      // Empty image: one side zero, the other any size
      w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
      h = (w == 0) ? $urandom_range(0, 65535) : 0;
    end else begin
      w = $urandom_range(256, 65535);
      h = $urandom_range(256, 65535);
    end
    total = w * h;

    file_q.push_back(id_len[7:0]);
    file_q.push_back(8'h00);
    file_q.push_back(rle ? TypeRle : TypeRaw);
    repeat (9) file_q.push_back(8'($urandom_range(0, 255)));
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    file_q.push_back(bpp);
    file_q.push_back(8'($urandom_range(0, 255)));

    if (!good) begin
      // Break one header field
      bad = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: file_q[1] = (bad == 8'd0) ? 8'd1 : bad;
        1: file_q[2] = (bad == TypeRaw || bad == TypeRle) ? bad + 8'd1 : bad;
        default: file_q[16] = (bad == Bpp24 || bad == Bpp32) ? bad + 8'd1 : bad;
      endcase
    end else begin
      repeat (id_len) file_q.push_back(8'($urandom_range(0, 255)));
      if (rle) begin
        rem = total;
        npkt = 0;
        max_pkt = (total > 64) ? 6 : 64;
        while (rem > 0 && npkt < max_pkt) begin
          if ($urandom_range(0, 9) == 0) cnt = $urandom_range(1, 128);
          else cnt = $urandom_range(1, (rem < 8) ? rem : 8);
          run = $urandom_range(0, 1);
          file_q.push_back({run, 7'(cnt - 1)});
          if (run) push_pixel(bpp == Bpp32);
          else repeat (cnt) push_pixel(bpp == Bpp32);
          rem = (cnt >= rem) ? 0 : rem - cnt;
          npkt++;
        end
      end else begin
        for (int unsigned i = 0; i < total && i < 48; i++) push_pixel(bpp == Bpp32);
      end
    end
    repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(0, 255)));
    if (!want_good && $urandom_range(0, 9) == 0) file_q = file_q[0:$urandom_range(0, 16)];
  endtask

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic string fmt_result(tga_result_t r);
    return $sformatf("kind=%0d start=%0d len=%0d bgra=%h_%h_%h_%h w=%0d h=%0d end=%b",
                     r.kind, r.span_start, r.span_length, r.blue, r.green, r.red,
                     r.alpha, r.width, r.height, r.image_end);
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin : result_check
    tga_result_t got;
    tga_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.kind        = tgadec_pkg::kind_e'(m_axis_tuser);
      got.span_start  = m_axis_tdata[31:0];
      got.span_length = m_axis_tdata[39:32];
      got.blue        = m_axis_tdata[47:40];
      got.green       = m_axis_tdata[55:48];
      got.red         = m_axis_tdata[63:56];
      got.alpha       = m_axis_tdata[71:64];
      got.width       = m_axis_tdata[87:72];
      got.height      = m_axis_tdata[103:88];
      got.image_end   = m_axis_tlast;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected: %s", $time, fmt_result(got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                   fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    reset_decoder();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (DirRows[i]) begin
      send_byte(DirRows[i].data, DirRows[i].start, DirRows[i].typed, EmptyHeaderResult);
    end

    // Random files; drop the gaps for the last stretch
    while (bytes_sent < RandomItems) begin
      if (bytes_sent > RandomItems * 85 / 100) gaps_on = 1'b0;
      if (!hold_done && bytes_sent > RandomItems / 3) begin
        hold_done = 1'b1;
        hold_off_req = 1'b1;
        build_file(1'b1);
      end else begin
        build_file(1'b0);
      end
      foreach (file_q[i]) send_byte(file_q[i], i == 0, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tgadec_pkg.sv
rtl/tgadec_core.sv
rtl/tga_rle_image_decoder.sv
tb/tb_tga_rle_image_decoder.sv
